@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the echo median fill level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i edge, skipped while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on any rising clk_i edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

@@ sv/emfl_pkg.sv @@
// Types and constants for the echo median fill level unit.
`default_nettype none

package emfl_pkg;

  // Ring depth, the slot counter width that follows from it, and the fill count width
  localparam int unsigned DEPTH  = 5;
  localparam int unsigned CNT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd4;

  localparam logic [15:0] RATE_RESET   = 16'd1124;
  localparam logic [15:0] MARGIN_RESET = 16'd32;

  // Fill scaling: tenths of a percent
  localparam logic [15:0] FILL_SCALE = 16'd1000;
  localparam logic [9:0]  FILL_MAX   = 10'd1000;
  localparam int unsigned DIV_BITS   = 10;

  // Sort entry: pad flag above the distance, so empty slots rank last
  typedef logic [16:0] emfl_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_STORE,
    ST_LOAD,
    ST_RANK,
    ST_MED,
    ST_FILL,
    ST_DIV,
    ST_OUT
  } emfl_state_e;

endpackage

`default_nettype wire

@@ sv/echo_median_fill_level_unit.sv @@
// Echo width to distance median filter with fill level, top level.
`default_nettype none

`include "assert_macros.svh"

// Each accepted word carries an echo width in microseconds. A zero width is
// taken and dropped without a result. Any other width is scaled by
// cm_per_us_rate (one shared 16x16 multiplier, product shifted right by 12
// and saturated to 16 bits) into a distance in 1/16 cm, written into a ring
// of the last DEPTH distances, and the median of the filled slots is found
// by a rank scan: every slot in turn is compared against every other slot by
// one less-than and one less-or-equal compare, DEPTH*DEPTH steps in all. With
// an even count the two middle values are averaged, rounding down. When
// calibrated with empty above full, a median at or above empty gives fill 0,
// one at or below full gives 1000, and any other gives the fill in tenths of
// a percent from one constant multiply on the same multiplier and a 10 step
// restoring divide on one subtractor; otherwise the fill is 0. The block
// works on one word at a time and holds in_stall_o high until its result has
// moved into the output register, which then waits for the consumer on its
// own. Configuration is to be written while idle; nothing enforces it.
module echo_median_fill_level_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [emfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [emfl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [15:0]                    echo_width_us_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [15:0]                         filtered_distance_o,
  output logic [9:0]                          fill_tenths_o,
  output logic                                out_of_range_o,
  output logic [emfl_pkg::FILL_W-1:0]          samples_held_o
);
  import emfl_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DEPTH - 1);

  // Configuration registers
  logic [15:0] rate_q, empty_q, full_q, margin_q;
  logic        cal_q;

  // Control state
  emfl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  slot_q, slot_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]  cand_q, cand_d;
  logic [3:0]        bit_q, bit_d;
  logic              out_valid_q, out_valid_d;

  // Datapath
  logic [15:0]       ring_q [DEPTH];
  emfl_entry_t       buf_q [DEPTH];
  emfl_entry_t       buf_d [DEPTH];
  logic [15:0]       width_q, width_d;
  logic [31:0]       prod_q, prod_d;
  logic [31:0]       dvs_q, dvs_d;
  logic [FILL_W-1:0] lt_q, lt_d, le_q, le_d;
  logic [FILL_W-1:0] k0_q, k0_d, k1_q, k1_d;
  emfl_entry_t       lo_q, lo_d, hi_q, hi_d;
  logic [15:0]       med_q, med_d;
  logic [9:0]        quo_q, quo_d;
  logic              oor_q, oor_d;
  logic [15:0]       out_dist_q, out_dist_d;
  logic [9:0]        out_fill_q, out_fill_d;
  logic              out_oor_q, out_oor_d;
  logic [FILL_W-1:0] out_held_q, out_held_d;

  // Shared units
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [32:0] trial;
  logic [15:0] conv_dist;
  logic        ring_we;
  logic [15:0] span, diff;
  logic [16:0] med_sum, oor_limit;
  logic        active;

  assign mul_p   = 32'(mul_a) * 32'(mul_b);
  assign trial   = {1'b0, prod_q} - {1'b0, dvs_q};
  assign conv_dist = (prod_q[31:28] != 4'd0) ? 16'hFFFF : prod_q[27:12];
  assign span    = empty_q - full_q;
  assign diff    = empty_q - med_q;
  assign med_sum = {1'b0, lo_q[15:0]} + {1'b0, hi_q[15:0]};
  assign oor_limit = {1'b0, empty_q} + {1'b0, margin_q};
  assign active  = cal_q && (empty_q > full_q);

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign filtered_distance_o = out_dist_q;
  assign fill_tenths_o       = out_fill_q;
  assign out_of_range_o      = out_oor_q;
  assign samples_held_o      = out_held_q;

  // Configuration: write only, unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= RATE_RESET;
      cal_q    <= 1'b0;
      empty_q  <= 16'd0;
      full_q   <= 16'd0;
      margin_q <= MARGIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RATE:   rate_q   <= cfg_wdata_i;
        CFG_CAL:    cal_q    <= cfg_wdata_i[0];
        CFG_EMPTY:  empty_q  <= cfg_wdata_i;
        CFG_FULL:   full_q   <= cfg_wdata_i;
        CFG_MARGIN: margin_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    step_d      = step_q;
    cand_d      = cand_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    buf_d       = buf_q;
    width_d     = width_q;
    prod_d      = prod_q;
    dvs_d       = dvs_q;
    lt_d        = lt_q;
    le_d        = le_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    med_d       = med_q;
    quo_d       = quo_q;
    oor_d       = oor_q;
    out_dist_d  = out_dist_q;
    out_fill_d  = out_fill_q;
    out_oor_d   = out_oor_q;
    out_held_d  = out_held_q;
    mul_a       = width_q;
    mul_b       = rate_q;
    ring_we     = 1'b0;

    // drop the waiting word once the consumer takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          width_d = echo_width_us_i;
          if (echo_width_us_i != 16'd0) begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        mul_a   = width_q;
        mul_b   = rate_q;
        prod_d  = mul_p;
        state_d = ST_STORE;
      end
      ST_STORE: begin
        ring_we = 1'b1;
        slot_d  = (slot_q == LAST) ? '0 : slot_q + 1'b1;
        if (fill_q < FILL_W'(DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // unfilled slots load as all ones with the pad flag set
        for (int i = 0; i < DEPTH; i++) begin
          buf_d[i] = (FILL_W'(i) >= fill_q) ? {1'b1, 16'hFFFF} : {1'b0, ring_q[i]};
        end
        k1_d    = fill_q >> 1;
        k0_d    = (fill_q - 1'b1) >> 1;
        step_d  = '0;
        cand_d  = '0;
        lt_d    = '0;
        le_d    = FILL_W'(1);
        state_d = ST_RANK;
      end
      ST_RANK: begin
        if (step_q != LAST) begin
          // count slot 1 against the candidate, rotate the others past it
          if (buf_q[1] < buf_q[0]) begin
            lt_d = lt_q + 1'b1;
          end
          if (buf_q[1] <= buf_q[0]) begin
            le_d = le_q + 1'b1;
          end
          for (int i = 1; i < DEPTH - 1; i++) begin
            buf_d[i] = buf_q[i+1];
          end
          buf_d[DEPTH-1] = buf_q[1];
          step_d = step_q + 1'b1;
        end else begin
          // candidate covers sorted places lt .. le-1
          if (lt_q <= k0_q && k0_q < le_q) begin
            lo_d = buf_q[0];
          end
          if (lt_q <= k1_q && k1_q < le_q) begin
            hi_d = buf_q[0];
          end
          for (int i = 0; i < DEPTH - 1; i++) begin
            buf_d[i] = buf_q[i+1];
          end
          buf_d[DEPTH-1] = buf_q[0];
          step_d = '0;
          lt_d   = '0;
          le_d   = FILL_W'(1);
          cand_d = cand_q + 1'b1;
          if (cand_q == LAST) begin
            state_d = ST_MED;
          end
        end
      end
      ST_MED: begin
        med_d   = med_sum[16:1];
        state_d = ST_FILL;
      end
      ST_FILL: begin
        oor_d   = active && ({1'b0, med_q} > oor_limit);
        quo_d   = '0;
        state_d = ST_OUT;
        if (active && med_q < empty_q) begin
          if (diff >= span) begin
            quo_d = FILL_MAX;
          end else begin
            // quotient fits 10 bits since diff < span
            mul_a   = diff;
            mul_b   = FILL_SCALE;
            prod_d  = mul_p;
            dvs_d   = {7'd0, span, 9'd0};
            bit_d   = 4'(DIV_BITS - 1);
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_d = {quo_q[8:0], !trial[32]};
        if (!trial[32]) begin
          prod_d = trial[31:0];
        end
        dvs_d = dvs_q >> 1;
        bit_d = bit_q - 1'b1;
        if (bit_q == 4'd0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_dist_d  = med_q;
          out_fill_d  = quo_q;
          out_oor_d   = oor_q;
          out_held_d  = fill_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      step_q      <= '0;
      cand_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      step_q      <= step_d;
      cand_q      <= cand_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    width_q    <= width_d;
    prod_q     <= prod_d;
    dvs_q      <= dvs_d;
    lt_q       <= lt_d;
    le_q       <= le_d;
    k0_q       <= k0_d;
    k1_q       <= k1_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    med_q      <= med_d;
    quo_q      <= quo_d;
    oor_q      <= oor_d;
    out_dist_q <= out_dist_d;
    out_fill_q <= out_fill_d;
    out_oor_q  <= out_oor_d;
    out_held_q <= out_held_d;
  end

  // Distance ring: one write port, slots read at fixed places on load
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[slot_q] <= conv_dist;
    end
  end

  `ASSERT_NEVER(a_ring_ptrs, (slot_q > LAST) || (fill_q > FILL_W'(DEPTH)), "ring pointer out of range")
  `ASSERT_CLK(a_fill_bound, out_valid_q |-> (out_fill_q <= FILL_MAX), "fill above 1000")
  `ASSERT_CLK(a_held_range, out_valid_q |-> (out_held_q != '0 && out_held_q <= FILL_W'(DEPTH)), "bad held count")
  `ASSERT_CLK(a_out_hold, (state_q == ST_OUT && out_valid_q && out_stall_i) |=> (state_q == ST_OUT && out_valid_q), "finished word lost while output stalled")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the echo median fill level unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import emfl_pkg::*;

  // Quiet time after the last result before a register write or the verdict.
  localparam int SETTLE_CYCLES  = 64;
  // Cycles with no word moving on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;
  // Random part: echo words with a nonzero width per register setting.
  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 130;

  typedef struct packed {
    logic [15:0] distance;
    logic [9:0]  fill;
    logic        oor;
    logic [2:0]  held;
  } level_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] echo_width = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [15:0]       filtered_distance;
  logic [9:0]        fill_tenths;
  logic              out_of_range;
  logic [FILL_W-1:0] samples_held;

  echo_median_fill_level_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .echo_width_us_i    (echo_width),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .filtered_distance_o(filtered_distance),
    .fill_tenths_o      (fill_tenths),
    .out_of_range_o     (out_of_range),
    .samples_held_o     (samples_held)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Level predictor: its own copy of the registers and the distance ring.
  // ---------------------------------------------------------------------
  logic [15:0] rate_cfg   = RATE_RESET;
  logic        cal_cfg    = 1'b0;
  logic [15:0] empty_cfg  = '0;
  logic [15:0] full_cfg   = '0;
  logic [15:0] margin_cfg = MARGIN_RESET;

  logic [15:0] dist_ring [DEPTH];
  int          ring_slot = 0;
  int          ring_held = 0;

  level_result_t level_queue [$];

  int errors        = 0;
  int words_sent    = 0;
  int no_echo_words = 0;
  int results_seen  = 0;
  int reg_writes    = 0;
  int burst_left    = 0;

  // Store one distance and work out the level result it causes.
  function automatic level_result_t predict_level(input logic [15:0] width);
    logic [31:0]   product;
    logic [15:0]   conv_dist;
    logic [15:0]   sorted [DEPTH];
    logic [15:0]   key;
    logic [15:0]   med;
    logic [16:0]   pair;
    logic [31:0]   quot;
    int            j;
    level_result_t r;
    product = ({16'd0, width} * {16'd0, rate_cfg}) >> 12;
    conv_dist = (product > 32'hFFFF) ? 16'hFFFF : product[15:0];
    dist_ring[ring_slot] = conv_dist;
    ring_slot = (ring_slot + 1 >= DEPTH) ? 0 : ring_slot + 1;
    if (ring_held < DEPTH) ring_held++;
    // Insertion sort of the filled slots; unwritten slots are never touched.
    for (int i = 0; i < ring_held; i++) sorted[i] = dist_ring[i];
    for (int i = 1; i < ring_held; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    if (ring_held % 2 == 1) begin
      med = sorted[ring_held/2];
    end else begin
      pair = {1'b0, sorted[ring_held/2-1]} + {1'b0, sorted[ring_held/2]};
      med = pair[16:1];
    end
    r.distance = med;
    r.fill = '0;
    r.oor = 1'b0;
    r.held = ring_held[2:0];
    if (cal_cfg && empty_cfg > full_cfg) begin
      if (med < empty_cfg) begin
        quot = ({16'd0, empty_cfg - med} * 32'd1000) / {16'd0, empty_cfg - full_cfg};
        r.fill = (quot > 32'(FILL_MAX)) ? FILL_MAX : quot[9:0];
      end
      // Compare against the unwrapped sum of empty distance and margin.
      r.oor = ({1'b0, med} > ({1'b0, empty_cfg} + {1'b0, margin_cfg}));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------
  task automatic send_echo(input logic [15:0] width);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0, 1: gap = 0;
        2: gap = $urandom_range(1, 8);
        default: gap = $urandom_range(9, 60);
      endcase
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid = 1'b1;
    echo_width = width;
    // Hold the word until the block takes it.
    do @(posedge clk_i); while (in_stall);
    words_sent++;
    if (width == 16'd0) no_echo_words++;
    else level_queue.push_back(predict_level(width));
  endtask

  // Drop valid, drain every pending result, then let the block go quiet.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid = 1'b0;
    burst_left = 0;
    while (level_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    case (idx)
      CFG_RATE:   rate_cfg = data;
      CFG_CAL:    cal_cfg = data[0];
      CFG_EMPTY:  empty_cfg = data;
      CFG_FULL:   full_cfg = data;
      CFG_MARGIN: margin_cfg = data;
      default: ;  // unmapped index: the block ignores it
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic write_all_regs(input logic [15:0] rate, input logic cal,
                                input logic [15:0] empty, input logic [15:0] full,
                                input logic [15:0] margin);
    write_reg(CFG_RATE, rate);
    // Put junk above bit 0 of the calibration flag; only bit 0 counts.
    write_reg(CFG_CAL, {15'($urandom), cal});
    write_reg(CFG_EMPTY, empty);
    write_reg(CFG_FULL, full);
    write_reg(CFG_MARGIN, margin);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern that switches between random modes.
  // ---------------------------------------------------------------------
  int rx_hold  = 0;
  int rx_mode  = 0;
  int rx_cycle = 0;

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall = 1'b1;
      rx_hold--;
    end else begin
      out_stall = 1'b0;
      case (rx_mode)
        1: if ($urandom_range(0, 1) == 1) rx_hold = $urandom_range(1, 3);
        2: if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(5, 40);
        default: ;  // free running, no stall
      endcase
    end
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
  end

  // ---------------------------------------------------------------------
  // Result check: every accepted word against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    level_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (level_queue.size() == 0) begin
        $error("result with nothing pending: filtered_distance %0d", filtered_distance);
        errors++;
      end else begin
        want = level_queue.pop_front();
        results_seen++;
        if (filtered_distance !== want.distance) begin
          $error("filtered_distance: expected %0d, actual %0d", want.distance,
                 filtered_distance);
          errors++;
        end
        if (fill_tenths !== want.fill) begin
          $error("fill_tenths: expected %0d, actual %0d", want.fill, fill_tenths);
          errors++;
        end
        if (out_of_range !== want.oor) begin
          $error("out_of_range: expected %0d, actual %0d", want.oor, out_of_range);
          errors++;
        end
        if (samples_held !== want.held) begin
          $error("samples_held: expected %0d, actual %0d", want.held, samples_held);
          errors++;
        end
      end
    end
  end

  // Watchdog: abandon the run when no word moves for too long.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[echo_median_fill_level_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset registers: no echo dropped, a width that scales to zero distance,
  // the widest width, and enough words to fill and wrap the ring.
  task automatic test_default_setup();
    send_echo(16'd0);
    send_echo(16'd1);
    send_echo(16'hFFFF);
    send_echo(16'd3644);
    send_echo(16'd0);
    send_echo(16'd2000);
    send_echo(16'd4000);
    send_echo(16'd1200);
  endtask

  // Unit rate so a width is a distance; walk the median past each fill edge.
  task automatic test_fill_edges();
    settle_block();
    write_all_regs(16'd4096, 1'b1, 16'd4000, 16'd1000, 16'd32);
    repeat (3) send_echo(16'd5000);  // well past empty: fill 0, out of range
    repeat (3) send_echo(16'd500);   // below full: fill clamps to 1000
    repeat (3) send_echo(16'd4000);  // exactly empty: fill 0, in range
    repeat (3) send_echo(16'd4033);  // one past empty plus margin
    repeat (3) send_echo(16'd1000);  // exactly full
  endtask

  // Saturating rate, unwrapped margin sum, empty not above full, unmapped
  // register indexes, and dropping calibration.
  task automatic test_config_extremes();
    settle_block();
    write_all_regs(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
    send_echo(16'hFFFF);
    send_echo(16'd1);
    settle_block();
    write_reg(CFG_EMPTY, 16'd500);
    write_reg(CFG_FULL, 16'd500);
    send_echo(16'd7);
    settle_block();
    for (int idx = CFG_MARGIN + 1; idx <= int'({CFG_IDX_W{1'b1}}); idx++)
      write_reg(idx[CFG_IDX_W-1:0], 16'($urandom));
    write_reg(CFG_CAL, 16'hFFFE);
    send_echo(16'd300);
  endtask

  // Random settings, then mostly widths aimed at the calibrated window,
  // some fully random widths, and a few words with no echo.
  task automatic test_random_levels();
    logic [15:0] rate;
    logic        cal;
    logic [15:0] empty;
    logic [15:0] full;
    logic [15:0] margin;
    logic [15:0] width;
    longint      target;
    longint      lo;
    longint      hi;
    longint      scaled;
    int          echoes;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      case ($urandom_range(0, 5))
        0: rate = 16'd0;
        1: rate = 16'hFFFF;
        2: rate = 16'd4096;
        default: rate = 16'($urandom);
      endcase
      cal = ($urandom_range(0, 3) != 0);
      empty = 16'($urandom);
      full = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, empty)) : 16'($urandom);
      case ($urandom_range(0, 3))
        0: margin = 16'd0;
        1: margin = 16'hFFFF;
        2: margin = 16'($urandom_range(0, 64));
        default: margin = 16'($urandom);
      endcase
      if (phase == 0) begin
        rate = 16'hFFFF; cal = 1'b1; empty = 16'hFFFF; full = 16'd0; margin = 16'hFFFF;
      end else if (phase == 1) begin
        rate = 16'd0; cal = 1'b1; full = 16'd0; margin = 16'd0;
      end
      write_all_regs(rate, cal, empty, full, margin);
      if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_W'(CFG_MARGIN + 1), 16'($urandom));
      echoes = 0;
      while (echoes < WORDS_PER_PHASE) begin
        case ($urandom_range(0, 19))
          0: width = 16'd0;
          1, 2, 3, 4, 5, 6, 7: width = 16'($urandom);
          default: begin
            if (rate == 16'd0) begin
              width = 16'($urandom);
            end else begin
              lo = (full > 16'd256) ? longint'(full) - 256 : 0;
              hi = longint'(empty) + longint'(margin) + 256;
              if (hi > 65535) hi = 65535;
              target = $urandom_range(int'(lo), int'(hi));
              scaled = (target << 12) / longint'(rate);
              if (scaled > 65535) scaled = 65535;
              if (scaled == 0) scaled = 1;
              width = scaled[15:0];
            end
          end
        endcase
        send_echo(width);
        if (width != 16'd0) echoes++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_setup();
    test_fill_edges();
    test_config_extremes();
    test_random_levels();
    settle_block();

    $display("Covered %0d echo words (%0d without echo) across %0d register writes.",
             words_sent, no_echo_words, reg_writes);
    $display("Checked %0d level results with %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("[echo_median_fill_level_unit] OK");
    end else begin
      $display("[echo_median_fill_level_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/emfl_pkg.sv
sv/echo_median_fill_level_unit.sv
tb/sv/testbench.sv
